// ----- rtl/jr_pkg.sv -----
// Package for the Jacobi 2x2 rotation factor pipeline.
// Holds the arctan segment tables, divider sizing, and the Q11 multiply and
// constant-divide helpers. No dependencies.
package jr_pkg;

  localparam int FRAC_BITS = 11;
  localparam logic signed [15:0] PI_HALF = 16'sd3216;
  localparam logic signed [15:0] ONE_Q11 = 16'sd2048;

  localparam int DIV_BITS   = 27;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

  localparam int TERM_W = 21;
  typedef logic signed [TERM_W-1:0] term_t;

  localparam logic [10:0] SEG_X [0:7] = '{
    11'd0, 11'd256, 11'd512, 11'd768, 11'd1024, 11'd1280, 11'd1536, 11'd1792
  };
  localparam logic [10:0] SEG_Y [0:7] = '{
    11'd0, 11'd254, 11'd501, 11'd734, 11'd949, 11'd1144, 11'd1317, 11'd1472
  };
  localparam logic [10:0] SEG_M [0:7] = '{
    11'd2037, 11'd1976, 11'd1864, 11'd1718, 11'd1555, 11'd1391, 11'd1234, 11'd1090
  };

  // ceil(2^k / C), exact for magnitudes up to 2^20
  localparam logic [21:0] RECIP_6    = 22'd2796203;
  localparam int          SHIFT_6    = 24;
  localparam logic [21:0] RECIP_24   = 22'd2796203;
  localparam int          SHIFT_24   = 26;
  localparam logic [21:0] RECIP_120  = 22'd2236963;
  localparam int          SHIFT_120  = 28;
  localparam logic [21:0] RECIP_720  = 22'd2982617;
  localparam int          SHIFT_720  = 31;
  localparam logic [21:0] RECIP_5040 = 22'd3408705;
  localparam int          SHIFT_5040 = 34;

  typedef struct packed {
    logic neg;
    logic zero;
    logic refl;
  } jr_flags_t;

  function automatic term_t qmul(term_t p, term_t q);
    logic signed [2*TERM_W-1:0] full;
    full = p * q;
    return full[31:FRAC_BITS];
  endfunction

  function automatic term_t cdiv(term_t v, logic [21:0] recip, int k);
    logic [TERM_W-1:0] mag;
    logic [42:0]       prod;
    logic [42:0]       quo;
    mag  = v[TERM_W-1] ? TERM_W'(-v) : TERM_W'(v);
    prod = 43'(mag) * 43'(recip);
    quo  = prod >> k;
    return v[TERM_W-1] ? -term_t'(quo[TERM_W-1:0]) : term_t'(quo[TERM_W-1:0]);
  endfunction

endpackage

// ----- rtl/jr_in_if.sv -----
// Input channel carrying one 2x2 Q11 matrix word.
// Depends on nothing.
interface jr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_top_left;
  logic signed [15:0] b_top_right;
  logic signed [15:0] c_bottom_left;
  logic signed [15:0] d_bottom_right;

  modport source (output valid, a_top_left, b_top_right, c_bottom_left, d_bottom_right,
                  input ready);
  modport sink (input valid, a_top_left, b_top_right, c_bottom_left, d_bottom_right,
                output ready);
endinterface

// ----- rtl/jr_out_if.sv -----
// Output channel carrying one word of rotation cosines and sines.
// Depends on nothing.
interface jr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cos_left;
  logic signed [15:0] sin_left;
  logic signed [15:0] cos_right;
  logic signed [15:0] sin_right;

  modport source (output valid, cos_left, sin_left, cos_right, sin_right, input ready);
  modport sink (input valid, cos_left, sin_left, cos_right, sin_right, output ready);
endinterface

// ----- rtl/jr_angle.sv -----
// One pair angle: magnitude compare, pipelined restoring divide, segment arctan.
// Depends on jr_pkg.
module jr_angle import jr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] num,
  input  logic signed [15:0] den,
  output logic               out_valid,
  output logic signed [15:0] angle
);

  logic signed [15:0] mag_n, mag_d, opnd, dvsr;
  logic               refl_c;
  logic [15:0]        ao, ad;
  jr_flags_t          flg_c;

  logic [15:0]         rem  [0:DIV_STAGES];
  logic [15:0]         quo  [0:DIV_STAGES];
  logic [DIV_BITS-1:0] dsh  [0:DIV_STAGES];
  logic [15:0]         dvs  [0:DIV_STAGES];
  jr_flags_t           flg  [0:DIV_STAGES];
  logic [DIV_STAGES:0] vld;

  logic [15:0]         rem_next [1:DIV_STAGES];
  logic [15:0]         quo_next [1:DIV_STAGES];
  logic [DIV_BITS-1:0] dsh_next [1:DIV_STAGES];

  logic [15:0] xq;
  logic [16:0] mx, span;
  logic [2:0]  idx_c;
  logic [27:0] prod_c;

  logic        b_vld;
  logic [27:0] b_prod;
  logic [2:0]  b_idx;
  logic        b_xneg, b_zero, b_refl;

  logic signed [15:0] r_c, rs_c, av_c, ang_c;
  logic               c_vld;

  always_comb begin
    mag_n  = num[15] ? -num : num;
    mag_d  = den[15] ? -den : den;
    refl_c = mag_n > mag_d;
    opnd   = refl_c ? den : num;
    dvsr   = refl_c ? num : den;
    ao     = opnd[15] ? 16'(-opnd) : 16'(opnd);
    ad     = dvsr[15] ? 16'(-dvsr) : 16'(dvsr);
    flg_c.neg  = opnd[15] ^ dvsr[15];
    flg_c.zero = (dvsr == 16'sd0);
    flg_c.refl = refl_c;
  end

  always_comb begin
    logic [16:0]         t;
    logic [15:0]         r;
    logic [15:0]         q;
    logic [DIV_BITS-1:0] sh;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r  = rem[s];
      q  = quo[s];
      sh = dsh[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < DIV_BITS) begin
          t  = {r, sh[DIV_BITS-1]};
          sh = {sh[DIV_BITS-2:0], 1'b0};
          if (t >= {1'b0, dvs[s]}) begin
            r = 16'(t - {1'b0, dvs[s]});
            q = {q[14:0], 1'b1};
          end else begin
            r = t[15:0];
            q = {q[14:0], 1'b0};
          end
        end
      end
      rem_next[s+1] = r;
      quo_next[s+1] = q;
      dsh_next[s+1] = sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      quo[0] <= '0;
      dsh[0] <= {ao, 11'b0};
      dvs[0] <= ad;
      flg[0] <= flg_c;
      for (int s = 1; s <= DIV_STAGES; s++) begin
        rem[s] <= rem_next[s];
        quo[s] <= quo_next[s];
        dsh[s] <= dsh_next[s];
        dvs[s] <= dvs[s-1];
        flg[s] <= flg[s-1];
      end
    end
  end

  always_comb begin
    xq     = flg[DIV_STAGES].neg ? 16'(-quo[DIV_STAGES]) : quo[DIV_STAGES];
    mx     = xq[15] ? 17'(-{xq[15], xq}) : {1'b0, xq};
    idx_c  = (|mx[16:11]) ? 3'd7 : mx[10:8];
    span   = mx - {6'b0, SEG_X[idx_c]};
    prod_c = 28'(SEG_M[idx_c]) * 28'(span);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      b_vld <= vld[DIV_STAGES];
      c_vld <= b_vld;
    end
  end

  always_comb begin
    r_c   = $signed({5'b0, SEG_Y[b_idx]}) + $signed(b_prod[26:FRAC_BITS]);
    rs_c  = b_xneg ? -r_c : r_c;
    av_c  = b_zero ? PI_HALF : rs_c;
    ang_c = b_refl ? PI_HALF - av_c : av_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_prod <= prod_c;
      b_idx  <= idx_c;
      b_xneg <= xq[15];
      b_zero <= flg[DIV_STAGES].zero;
      b_refl <= flg[DIV_STAGES].refl;
      angle  <= ang_c;
    end
  end

  assign out_valid = c_vld;

endmodule

// ----- rtl/jr_trig.sv -----
// Q11 Taylor cosine and sine of one angle over a six-stage multiply pipeline.
// Depends on jr_pkg.
module jr_trig import jr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  output logic signed [15:0] cos_v,
  output logic signed [15:0] sin_v
);

  logic [5:0] vld;
  term_t x_in;
  term_t s1_x, s1_x2;
  term_t s2_x, s2_x2, s2_x3, s2_x4;
  term_t s3_x, s3_x2, s3_d3, s3_d4, s3_x5, s3_x6;
  term_t s4_x, s4_x2, s4_d3, s4_d4, s4_x7, s4_d5, s4_d6;
  term_t s5_x, s5_x2, s5_d3, s5_d4, s5_d5, s5_d6, s5_d7;

  assign x_in = term_t'(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x  <= x_in;
      s1_x2 <= qmul(x_in, x_in);

      s2_x  <= s1_x;
      s2_x2 <= s1_x2;
      s2_x3 <= qmul(s1_x2, s1_x);
      s2_x4 <= qmul(s1_x2, s1_x2);

      s3_x  <= s2_x;
      s3_x2 <= s2_x2;
      s3_d3 <= cdiv(s2_x3, RECIP_6, SHIFT_6);
      s3_d4 <= cdiv(s2_x4, RECIP_24, SHIFT_24);
      s3_x5 <= qmul(s2_x3, s2_x2);
      s3_x6 <= qmul(s2_x4, s2_x2);

      s4_x  <= s3_x;
      s4_x2 <= s3_x2;
      s4_d3 <= s3_d3;
      s4_d4 <= s3_d4;
      s4_x7 <= qmul(s3_x5, s3_x2);
      s4_d5 <= cdiv(s3_x5, RECIP_120, SHIFT_120);
      s4_d6 <= cdiv(s3_x6, RECIP_720, SHIFT_720);

      s5_x  <= s4_x;
      s5_x2 <= s4_x2;
      s5_d3 <= s4_d3;
      s5_d4 <= s4_d4;
      s5_d5 <= s4_d5;
      s5_d6 <= s4_d6;
      s5_d7 <= cdiv(s4_x7, RECIP_5040, SHIFT_5040);

      sin_v <= s5_x[15:0] - s5_d3[15:0] + s5_d5[15:0] - s5_d7[15:0];
      cos_v <= ONE_Q11 - s5_x2[16:1] + s5_d4[15:0] - s5_d6[15:0];
    end
  end

  assign out_valid = vld[5];

endmodule

// ----- rtl/jacobi_2x2_rotation_factors.sv -----
// Top level of the Jacobi 2x2 rotation factor pipeline.
// Depends on jr_pkg, jr_in_if, jr_out_if, jr_angle and jr_trig.
//
// Usage:
//   matrix  : sink channel, one word holds a 2x2 Q11 matrix [[a,b],[c,d]].
//   factors : source channel, one word holds cos/sin of the left and right
//             rotation angles, Q11.
// A word is moved when valid and ready are both high at a rising clock edge.
// Throughput is one word per cycle unless factors stalls; every stage register
// advances together. Stages: one operand stage, seven restoring-divide stages
// of up to four quotient bits each, two arctan segment stages, one half-angle
// stage and six Taylor-series multiply stages, the last being the output register.
// Reset (rst, synchronous) clears every stage valid bit; no word is in flight
// afterwards and matrix.ready is high.
// When factors.ready is low with a word waiting, the whole pipeline holds and
// matrix.ready drops in the same cycle, so nothing is dropped or repeated.
module jacobi_2x2_rotation_factors import jr_pkg::*; (
  input  logic clk,
  input  logic rst,
  jr_in_if.sink     matrix,
  jr_out_if.source  factors
);

  logic               en;
  logic signed [15:0] sum_num, sum_den, dif_num, dif_den;
  logic               sum_vld, dif_vld;
  logic signed [15:0] sum_ang, dif_ang;
  logic [16:0]        ls, rs, ls_adj, rs_adj;
  logic               h_vld;
  logic signed [15:0] t_left, t_right;
  logic               lv, rv;

  assign en           = !factors.valid || factors.ready;
  assign matrix.ready = en;

  assign sum_num = matrix.c_bottom_left + matrix.b_top_right;
  assign sum_den = matrix.d_bottom_right - matrix.a_top_left;
  assign dif_num = matrix.c_bottom_left - matrix.b_top_right;
  assign dif_den = matrix.d_bottom_right + matrix.a_top_left;

  jr_angle u_sum (
    .clk(clk), .rst(rst), .en(en), .in_valid(matrix.valid),
    .num(sum_num), .den(sum_den), .out_valid(sum_vld), .angle(sum_ang)
  );

  jr_angle u_dif (
    .clk(clk), .rst(rst), .en(en), .in_valid(matrix.valid),
    .num(dif_num), .den(dif_den), .out_valid(dif_vld), .angle(dif_ang)
  );

  always_comb begin
    ls     = {sum_ang[15], sum_ang} - {dif_ang[15], dif_ang};
    rs     = {sum_ang[15], sum_ang} + {dif_ang[15], dif_ang};
    ls_adj = ls + {16'b0, ls[16]};
    rs_adj = rs + {16'b0, rs[16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (en) begin
      h_vld <= sum_vld & dif_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_left  <= ls_adj[16:1];
      t_right <= rs_adj[16:1];
    end
  end

  jr_trig u_left (
    .clk(clk), .rst(rst), .en(en), .in_valid(h_vld), .angle(t_left),
    .out_valid(lv), .cos_v(factors.cos_left), .sin_v(factors.sin_left)
  );

  jr_trig u_right (
    .clk(clk), .rst(rst), .en(en), .in_valid(h_vld), .angle(t_right),
    .out_valid(rv), .cos_v(factors.cos_right), .sin_v(factors.sin_right)
  );

  assign factors.valid = lv & rv;

endmodule

// ----- rtl/jr_check.sv -----
// Port-level checker for the rotation factor pipeline, bound to the top level.
// Depends on jacobi_2x2_rotation_factors.
module jr_check (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with empty output stage");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

endmodule

bind jacobi_2x2_rotation_factors jr_check u_jr_check (
  .clk(clk),
  .rst(rst),
  .in_ready(matrix.ready),
  .out_valid(factors.valid),
  .out_ready(factors.ready),
  .out_word({factors.cos_left, factors.sin_left, factors.cos_right, factors.sin_right})
);
